// ===== design/range_max_segment_tree_unit_defines.svh =====
// assertion macros for the range max segment tree checker
`ifndef RANGE_MAX_SEGMENT_TREE_UNIT_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_UNIT_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define RMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define RMST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/rmst_pkg.sv =====
// shared constants, types and the signed maximum function for the segment tree
package rmst_pkg;

    localparam int DATA_W         = 32;
    localparam int POS_W          = 10;
    localparam int RANGE_W        = 11;
    localparam int OP_W           = 2;
    localparam int DEFAULT_LEAVES = 1024;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // max start value, one above the most negative; every node's reset value
    localparam logic signed [DATA_W-1:0] NEUTRAL = 32'sh8000_0001;

    // result word handed from the sequencer to the output register
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } res_t;

    function automatic logic signed [DATA_W-1:0] max_signed(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

// ===== design/rmst_mem.sv =====
// node memory: one write port, two read ports with registered read data
module rmst_mem
    import rmst_pkg::*;
#(
    parameter int LEAVES = DEFAULT_LEAVES,
    localparam int NODE_W = $clog2(2 * LEAVES)
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [NODE_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [NODE_W-1:0]        raddr0,
    input  logic [NODE_W-1:0]        raddr1,
    output logic signed [DATA_W-1:0] rdata0,
    output logic signed [DATA_W-1:0] rdata1
);

    localparam int DEPTH = 2 * LEAVES;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd0_reg;
    logic signed [DATA_W-1:0] rd1_reg;

    // synchronous write and reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// ===== design/rmst_ctrl.sv =====
// sequencer: clearing pass, leaf update climb, range walk and leaf read
module rmst_ctrl
    import rmst_pkg::*;
#(
    parameter int LEAVES = DEFAULT_LEAVES,
    localparam int NODE_W = $clog2(2 * LEAVES)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [POS_W-1:0]         position,
    input  logic [RANGE_W-1:0]       range_start,
    input  logic [RANGE_W-1:0]       range_end,
    input  logic signed [DATA_W-1:0] new_value,
    output logic                     mem_we,
    output logic [NODE_W-1:0]        mem_waddr,
    output logic signed [DATA_W-1:0] mem_wdata,
    output logic [NODE_W-1:0]        mem_raddr0,
    output logic [NODE_W-1:0]        mem_raddr1,
    input  logic signed [DATA_W-1:0] mem_rdata0,
    input  logic signed [DATA_W-1:0] mem_rdata1,
    output res_t                     res,
    input  logic                     res_take
);

    // walk counters reach 2*LEAVES, so they need one bit above the node index
    localparam int CNT_W = NODE_W + 1;
    localparam int CMP_W = (CNT_W > RANGE_W) ? CNT_W : RANGE_W;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * LEAVES - 1);
    localparam logic [CMP_W-1:0]  LEAVES_C  = CMP_W'(LEAVES);
    localparam logic [CNT_W-1:0]  LEAVES_N  = CNT_W'(LEAVES);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_CLIMB,
        S_QUERY,
        S_RDATA,
        S_EMIT
    } state_t;

    state_t                   state_reg,   state_next;
    logic [NODE_W-1:0]        clr_reg,     clr_next;
    logic [NODE_W-1:0]        node_reg,    node_next;
    logic signed [DATA_W-1:0] cur_reg,     cur_next;
    logic [CNT_W-1:0]         lo_reg,      lo_next;
    logic [CNT_W-1:0]         hi_reg,      hi_next;
    logic signed [DATA_W-1:0] acc_reg,     acc_next;
    logic                     pend_lo_reg, pend_lo_next;
    logic                     pend_hi_reg, pend_hi_next;
    logic signed [DATA_W-1:0] res_reg,     res_next;

    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         start_w;
    logic [CMP_W-1:0]         end_w;
    logic [CMP_W-1:0]         start_c;
    logic [CMP_W-1:0]         end_c;
    logic                     pos_ok;
    logic [NODE_W-1:0]        leaf;
    logic [NODE_W-1:0]        parent;
    logic signed [DATA_W-1:0] climb_max;
    logic signed [DATA_W-1:0] cand_lo;
    logic signed [DATA_W-1:0] cand_hi;
    logic signed [DATA_W-1:0] walk_max;
    logic [CNT_W-1:0]         hi_dec;

    // input decode: bounds check and clamping done at a width that holds both sides
    always_comb
    begin
        pos_w   = CMP_W'(position);
        start_w = CMP_W'(range_start);
        end_w   = CMP_W'(range_end);
        start_c = (start_w > LEAVES_C) ? LEAVES_C : start_w;
        end_c   = (end_w > LEAVES_C) ? LEAVES_C : end_w;
        pos_ok  = (pos_w < LEAVES_C);
        leaf    = NODE_W'(pos_w + LEAVES_C);
    end

    // per level arithmetic of the climb and the range walk
    always_comb
    begin
        parent    = node_reg >> 1;
        climb_max = max_signed(cur_reg, mem_rdata0);
        cand_lo   = pend_lo_reg ? mem_rdata0 : NEUTRAL;
        cand_hi   = pend_hi_reg ? mem_rdata1 : NEUTRAL;
        walk_max  = max_signed(acc_reg, max_signed(cand_lo, cand_hi));
        hi_dec    = hi_reg - CNT_W'(1);
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and memory requests
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        node_next    = node_reg;
        cur_next     = cur_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        acc_next     = acc_reg;
        pend_lo_next = pend_lo_reg;
        pend_hi_next = pend_hi_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = NEUTRAL;
        mem_raddr0   = '0;
        mem_raddr1   = '0;
        res.valid    = 1'b0;
        res.data     = res_reg;

        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_SET:
                        begin
                            if (pos_ok)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = leaf;
                                mem_wdata  = new_value;
                                mem_raddr0 = leaf ^ NODE_W'(1);
                                node_next  = leaf;
                                cur_next   = new_value;
                                state_next = S_CLIMB;
                            end
                        end
                        OP_QUERY:
                        begin
                            lo_next      = CNT_W'(start_c) + LEAVES_N;
                            hi_next      = CNT_W'(end_c) + LEAVES_N;
                            acc_next     = NEUTRAL;
                            pend_lo_next = 1'b0;
                            pend_hi_next = 1'b0;
                            state_next   = S_QUERY;
                        end
                        OP_READ:
                        begin
                            if (pos_ok)
                            begin
                                mem_raddr0 = leaf;
                                state_next = S_RDATA;
                            end
                            else
                            begin
                                res_next   = NEUTRAL;
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // sibling arrives, parent written, next sibling requested
            S_CLIMB:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = climb_max;
                cur_next  = climb_max;
                node_next = parent;
                if (parent > NODE_W'(1))
                begin
                    mem_raddr0 = parent ^ NODE_W'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // fold last level's nodes and request the boundary nodes of this one
            S_QUERY:
            begin
                acc_next = walk_max;
                if (lo_reg < hi_reg)
                begin
                    pend_lo_next = lo_reg[0];
                    pend_hi_next = hi_reg[0];
                    mem_raddr0   = lo_reg[NODE_W-1:0];
                    mem_raddr1   = hi_dec[NODE_W-1:0];
                    lo_next      = (lo_reg + CNT_W'(lo_reg[0])) >> 1;
                    hi_next      = hi_reg >> 1;
                end
                else
                begin
                    pend_lo_next = 1'b0;
                    pend_hi_next = 1'b0;
                    res_next     = walk_max;
                    state_next   = S_EMIT;
                end
            end

            S_RDATA:
            begin
                res_next   = mem_rdata0;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                res.valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            node_reg    <= '0;
            cur_reg     <= NEUTRAL;
            lo_reg      <= '0;
            hi_reg      <= '0;
            acc_reg     <= NEUTRAL;
            pend_lo_reg <= 1'b0;
            pend_hi_reg <= 1'b0;
            res_reg     <= NEUTRAL;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            node_reg    <= node_next;
            cur_reg     <= cur_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            acc_reg     <= acc_next;
            pend_lo_reg <= pend_lo_next;
            pend_hi_reg <= pend_hi_next;
            res_reg     <= res_next;
        end
    end

endmodule

// ===== design/range_max_segment_tree_unit.sv =====
// top level of the range maximum segment tree with point update
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid / in_stall   | op, position, range_start, range_end, new_value
//   out     | output    | out_valid / out_stall | answer
//
// after reset the node memory is cleared one entry a cycle, with in_stall high throughout
// set: the leaf, then one tree level per cycle on the single node memory write port
// query: one level per cycle with two memory reads a level
// read: the leaf is read, then emitted; one item is worked on at a time, in_stall is high while it runs
// a finished word waits in the output register; out_stall only holds the sequencer at its
// last cycle when that register is still full
module range_max_segment_tree_unit
    import rmst_pkg::*;
#(
    parameter int LEAVES = DEFAULT_LEAVES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [POS_W-1:0]         position,
    input  logic [RANGE_W-1:0]       range_start,
    input  logic [RANGE_W-1:0]       range_end,
    input  logic signed [DATA_W-1:0] new_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] answer
);

    localparam int NODE_W = $clog2(2 * LEAVES);

    logic                     mem_we;
    logic [NODE_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [NODE_W-1:0]        mem_raddr0;
    logic [NODE_W-1:0]        mem_raddr1;
    logic signed [DATA_W-1:0] mem_rdata0;
    logic signed [DATA_W-1:0] mem_rdata1;
    res_t                     res;
    logic                     res_take;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] answer_reg;

    rmst_mem #(
        .LEAVES (LEAVES)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

    rmst_ctrl #(
        .LEAVES (LEAVES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .position    (position),
        .range_start (range_start),
        .range_end   (range_end),
        .new_value   (new_value),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr0  (mem_raddr0),
        .mem_raddr1  (mem_raddr1),
        .mem_rdata0  (mem_rdata0),
        .mem_rdata1  (mem_rdata1),
        .res         (res),
        .res_take    (res_take)
    );

    // output register takes a word when empty or when its word leaves
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output word, no reset needed
    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
        begin
            answer_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;

endmodule

// ===== design/rmst_chk.sv =====
// port checker for the range maximum segment tree and its bind
`include "range_max_segment_tree_unit_defines.svh"

module rmst_chk
    import rmst_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [OP_W-1:0]          op,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [DATA_W-1:0] answer
);

    logic probe_taken;

    // a query or read word accepted at this edge
    assign probe_taken = in_valid && !in_stall && (op == OP_QUERY || op == OP_READ);

    // a stalled word stays offered
    `RMST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out word dropped")

    // a stalled word does not change
    `RMST_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(answer), "out word changed")

    // a query or read keeps the block busy in the following cycle
    `RMST_ASSERT_NEXT(a_busy_after_accept, probe_taken, in_stall, "query or read not busy")

    // a new result only appears after the block was busy
    `RMST_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall), "result while idle")

endmodule

bind range_max_segment_tree_unit rmst_chk u_rmst_chk (.*);

// ===== verif/range_max_segment_tree_unit_tb.sv =====
// range max segment tree testbench: directed and random set, query and read words vs a tree model
module range_max_segment_tree_unit_tb;
    import rmst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES       = DEFAULT_LEAVES;
    localparam int RANDOM_WORDS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int RANGE_TOP    = (1 << RANGE_W) - 1;

    // the one opcode the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one input word plus the sender's idling for it
    typedef struct {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic [RANGE_W-1:0]       range_start;
        logic [RANGE_W-1:0]       range_end;
        logic signed [DATA_W-1:0] new_value;
        int                       gap;
        bit                       drain;
    } tree_word_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op          = '0;
    logic [POS_W-1:0]         position    = '0;
    logic [RANGE_W-1:0]       range_start = '0;
    logic [RANGE_W-1:0]       range_end   = '0;
    logic signed [DATA_W-1:0] new_value   = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic signed [DATA_W-1:0] answer;

    tree_word_t               pending_words[$];
    logic signed [DATA_W-1:0] expected_answers[$];
    logic signed [DATA_W-1:0] node_max[2*LEAVES];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  gap_mode    = 0;
    int  stall_mode  = 0;
    int  idle_left   = 0;
    int  stall_left  = 0;
    int  answers_in  = 0;
    bit  next_drains = 1'b0;
    bit  word_taken;

    range_max_segment_tree_unit #(
        .LEAVES(LEAVES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .position   (position),
        .range_start(range_start),
        .range_end  (range_end),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .answer     (answer)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // reset, once
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idle cycles for one word: none, a uniform draw, or mostly none with an occasional wait
    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] higher_of(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

    // leaf write and ancestor refresh
    function automatic void tree_store(int unsigned leaf, logic signed [DATA_W-1:0] val);
        int unsigned idx;
        if (leaf >= LEAVES)
            return;
        idx = LEAVES + leaf;
        node_max[idx] = val;
        while (idx > 1)
        begin
            idx = idx >> 1;
            node_max[idx] = higher_of(node_max[2*idx], node_max[2*idx+1]);
        end
    endfunction

    // maximum over [lo, hi), bounds saturated at the leaf count
    function automatic logic signed [DATA_W-1:0] tree_range_max(int unsigned lo, int unsigned hi);
        logic signed [DATA_W-1:0] best;
        best = NEUTRAL;
        if (lo > LEAVES)
            lo = LEAVES;
        if (hi > LEAVES)
            hi = LEAVES;
        if (lo >= hi)
            return best;
        lo += LEAVES;
        hi += LEAVES;
        while (lo < hi)
        begin
            if (lo % 2 == 1)
            begin
                best = higher_of(best, node_max[lo]);
                lo++;
            end
            if (hi % 2 == 1)
            begin
                hi--;
                best = higher_of(best, node_max[hi]);
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        return best;
    endfunction

    // apply one accepted word to the tree and queue the answer it gives
    function automatic void tree_apply(tree_word_t w);
        case (w.op)
            OP_SET:
                tree_store(w.position, w.new_value);
            OP_QUERY:
                expected_answers.push_back(tree_range_max(w.range_start, w.range_end));
            OP_READ:
                expected_answers.push_back((w.position < LEAVES) ?
                                           node_max[LEAVES + w.position] : NEUTRAL);
            default:
                ;
        endcase
    endfunction

    function automatic void add_word(
        logic [OP_W-1:0]          w_op,
        int unsigned              w_pos,
        int unsigned              w_lo,
        int unsigned              w_hi,
        logic signed [DATA_W-1:0] w_val
    );
        tree_word_t w;
        w.op          = w_op;
        w.position    = w_pos[POS_W-1:0];
        w.range_start = (w_lo > RANGE_TOP) ? RANGE_TOP[RANGE_W-1:0] : w_lo[RANGE_W-1:0];
        w.range_end   = (w_hi > RANGE_TOP) ? RANGE_TOP[RANGE_W-1:0] : w_hi[RANGE_W-1:0];
        w.new_value   = w_val;
        w.gap         = draw_wait(gap_mode);
        w.drain       = next_drains;
        next_drains   = 1'b0;
        pending_words.push_back(w);
    endfunction

    // values biased towards the signed extremes and the neutral value
    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 5))
            0:
                case ($urandom_range(0, 6))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return NEUTRAL;
                    3:       return 32'sh8000_0002;
                    4:       return 32'sh0000_0000;
                    5:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            1:       return $signed($urandom_range(0, 200)) - 100;
            default: return $signed($urandom);
        endcase
    endfunction

    // stimulus and end of run
    initial
    begin
        int unsigned base;
        int unsigned span;
        int unsigned lo;
        int          counted;
        int          segment;
        int          kind;
        bit          drained_mid;

        for (int k = 0; k < 2*LEAVES; k++)
            node_max[k] = NEUTRAL;

        // directed: reset contents, extremes, empty and saturated ranges, unused opcode
        add_word(OP_READ,   0,     $urandom, $urandom, $urandom);
        add_word(OP_QUERY,  $urandom, 0, 1024, $urandom);
        add_word(OP_SET,    0,     $urandom, $urandom, 32'sh7FFF_FFFF);
        add_word(OP_SET,    1023,  $urandom, $urandom, 32'sh8000_0000);
        add_word(OP_READ,   1023,  $urandom, $urandom, $urandom);
        add_word(OP_QUERY,  $urandom, 1023, 1024, $urandom);
        add_word(OP_SET,    512,   $urandom, $urandom, -32'sd1);
        add_word(OP_QUERY,  $urandom, 0, 1024, $urandom);
        add_word(OP_QUERY,  $urandom, 1, 1024, $urandom);
        add_word(OP_QUERY,  $urandom, 5, 5, $urandom);
        add_word(OP_QUERY,  $urandom, 900, 10, $urandom);
        add_word(OP_SET,    1000,  $urandom, $urandom, 32'sd123);
        add_word(OP_QUERY,  $urandom, 1000, 2047, $urandom);
        add_word(OP_QUERY,  $urandom, 2047, 2047, $urandom);
        add_word(OP_QUERY,  $urandom, 1024, 2047, $urandom);
        add_word(OP_UNUSED, 1023,  2047, 2047, -32'sd1);
        add_word(OP_READ,   512,   $urandom, $urandom, $urandom);
        add_word(OP_SET,    0,     $urandom, $urandom, 32'sd0);
        add_word(OP_QUERY,  $urandom, 0, 1, $urandom);
        add_word(OP_QUERY,  $urandom, 0, 2047, $urandom);
        add_word(OP_SET,    'h2AA, 'h555, 'h2AA, 32'sh5555_5555);
        add_word(OP_SET,    'h155, 'h2AA, 'h555, 32'shAAAA_AAAA);
        add_word(OP_QUERY,  'h155, 'h155, 'h2AB, 32'sh5555_5555);
        add_word(OP_READ,   'h2AA, $urandom, $urandom, $urandom);
        add_word(OP_QUERY,  $urandom, 2047, 0, $urandom);

        // random: bursts of sets into a window, then probes around it
        counted     = 0;
        segment     = -1;
        drained_mid = 1'b0;
        next_drains = 1'b1;
        while (counted < RANDOM_WORDS)
        begin
            if (counted / 60 != segment)
            begin
                segment  = counted / 60;
                gap_mode = $urandom_range(0, 2);
            end
            if (!drained_mid && counted >= RANDOM_WORDS / 2)
            begin
                drained_mid = 1'b1;
                next_drains = 1'b1;
            end
            base = $urandom_range(0, LEAVES - 1);
            case ($urandom_range(0, 4))
                0:       span = 1;
                1:       span = 2;
                2:       span = 8;
                3:       span = 64;
                default: span = LEAVES;
            endcase
            repeat ($urandom_range(1, 6))
            begin
                add_word(OP_SET, (base + $urandom_range(0, span - 1)) % LEAVES,
                         $urandom, $urandom, draw_value());
                counted++;
            end
            repeat ($urandom_range(1, 6))
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 4)
                begin
                    lo = base + $urandom_range(0, span);
                    add_word(OP_QUERY, $urandom, lo, lo + $urandom_range(0, span), $urandom);
                    counted++;
                end
                else if (kind == 5)
                begin
                    add_word(OP_QUERY, $urandom, $urandom_range(0, RANGE_TOP),
                             $urandom_range(0, RANGE_TOP), $urandom);
                    counted++;
                end
                else if (kind <= 7)
                begin
                    add_word(OP_READ, (base + $urandom_range(0, span - 1)) % LEAVES,
                             $urandom, $urandom, $urandom);
                    counted++;
                end
                else if (kind == 8)
                begin
                    add_word(OP_READ, $urandom, $urandom, $urandom, $urandom);
                    counted++;
                end
                else
                begin
                    // noise: ignored opcode
                    add_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end

        // wait for the last word and its answer, then let a trailing set finish
        @(posedge rst_n);
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // driver: present the front word, retire it on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            word_taken = in_valid && !in_stall;
            if (word_taken)
            begin
                tree_apply(pending_words[0]);
                void'(pending_words.pop_front());
                idle_left = (pending_words.size() != 0) ? pending_words[0].gap : 0;
            end
            if (word_taken || !in_valid)
            begin
                if (pending_words.size() == 0)
                    in_valid <= 1'b0;
                else if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                // hold off until every outstanding answer is back
                else if (pending_words[0].drain && expected_answers.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid    <= 1'b1;
                    op          <= pending_words[0].op;
                    position    <= pending_words[0].position;
                    range_start <= pending_words[0].range_start;
                    range_end   <= pending_words[0].range_end;
                    new_value   <= pending_words[0].new_value;
                end
            end
        end
    end

    // monitor: compare each answer word with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: answer with none expected, expected none actual %0d",
                         $time, answer);
                mismatches++;
            end
            else
            begin
                if (answer !== expected_answers[0])
                begin
                    $display("%0t: answer mismatch, expected %0d actual %0d",
                             $time, expected_answers[0], answer);
                    mismatches++;
                end
                void'(expected_answers.pop_front());
            end
            answers_in++;
            if (answers_in % 40 == 0)
                stall_mode = $urandom_range(0, 2);
            stall_left = draw_wait(stall_mode);
            out_stall <= (stall_left > 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
